// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dpt_pkg.sv =====
// shared types, constants and microcode table for the debounced press timer
// no dependencies
package dpt_pkg;

    localparam int DEF_COUNT_BITS = 31;
    localparam int DEF_MAX_DIGITS = 10;

    localparam logic [15:0] STEP_INC_RESET = 16'd100;
    localparam int          CFG_ADDR_BITS  = 3;
    localparam logic        REG_STEP_INC   = 1'b0;   // word index of step_increment

    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    typedef enum logic [1:0] {
        DB_UP,
        DB_FALLING,
        DB_DOWN,
        DB_RISING
    } db_state_t;

    localparam int PC_BITS = 3;
    typedef logic [PC_BITS-1:0] pc_t;

    localparam pc_t STEP_IDLE = 3'd0;
    localparam pc_t STEP_CONV = 3'd1;
    localparam pc_t STEP_SKIP = 3'd2;
    localparam pc_t STEP_EMIT = 3'd3;
    localparam pc_t STEP_NL   = 3'd4;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_REPORT,
        COND_BIT_LAST,
        COND_LEAD_END,
        COND_DIGIT_DONE,
        COND_OUT_ACK
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        logic  load;
        logic  shift;
        logic  idx_dec;
        logic  out_valid;
        logic  out_nl;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic idx_dec;
        logic out_nl;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic bit_last;
        logic lead_end;
        logic idx_zero;
    } stat_t;

    function automatic ucode_t rom_word(input pc_t pc);
        ucode_t w;
        w = '{in_ready: 1'b0, load: 1'b0, shift: 1'b0, idx_dec: 1'b0,
              out_valid: 1'b0, out_nl: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
        case (pc)
            STEP_IDLE: begin
                w.in_ready = 1'b1;
                w.load     = 1'b1;
                w.cond     = COND_REPORT;
                w.target   = STEP_CONV;
            end
            STEP_CONV: begin
                w.shift  = 1'b1;
                w.cond   = COND_BIT_LAST;
                w.target = STEP_SKIP;
            end
            STEP_SKIP: begin
                w.idx_dec = 1'b1;
                w.cond    = COND_LEAD_END;
                w.target  = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.out_valid = 1'b1;
                w.idx_dec   = 1'b1;
                w.cond      = COND_DIGIT_DONE;
                w.target    = STEP_NL;
            end
            STEP_NL: begin
                w.out_valid = 1'b1;
                w.out_nl    = 1'b1;
                w.cond      = COND_OUT_ACK;
                w.target    = STEP_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // smaller of 2^cb - 1 and 10^md - 1
    function automatic logic [63:0] count_limit(input int cb, input int md);
        longint unsigned bin_lim;
        longint unsigned dec_lim;
        bin_lim = (64'd1 << cb) - 64'd1;
        dec_lim = 64'd1;
        for (int i = 0; i < md; i++) begin
            dec_lim = dec_lim * 64'd10;
        end
        dec_lim = dec_lim - 64'd1;
        return (bin_lim < dec_lim) ? bin_lim : dec_lim;
    endfunction

endpackage

// ===== sv/debounced_press_timer_ascii.sv =====
// top level of the debounced press timer with decimal ascii report
// depends on dpt_pkg, dpt_front, dpt_seq, dpt_conv
//
// Each input item is one sample of the button pin (0 = pressed). A tick that
// confirms no release is taken and gives no output. A tick that confirms a
// release starts a report: the count is converted to bcd one bit per cycle in
// the bit-serial conversion loop of the microcoded sequencer, the leading
// digits are scanned one per cycle, then each digit and the closing newline
// are offered on the m_ side and each is held until accepted. No new sample
// is taken until the newline has been accepted.
module debounced_press_timer_ascii #(
    parameter int COUNT_BITS = dpt_pkg::DEF_COUNT_BITS,
    parameter int MAX_DIGITS = dpt_pkg::DEF_MAX_DIGITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [0] pin_level, rest zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] ascii_char
    output logic                              m_tlast,   // last_char
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dpt_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [15:0]           step_inc_reg;
    logic                  in_fire;
    logic                  report;
    logic [COUNT_BITS-1:0] count;
    dpt_pkg::ctrl_t        ctrl;
    dpt_pkg::stat_t        stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_inc_reg <= dpt_pkg::STEP_INC_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == dpt_pkg::REG_STEP_INC) begin
            step_inc_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == dpt_pkg::REG_STEP_INC) ? {16'd0, step_inc_reg} : 32'd0;

    assign in_fire = s_tvalid & s_tready;

    dpt_front #(
        .COUNT_BITS(COUNT_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .pin_level(s_tdata[0]),
        .step_inc (step_inc_reg),
        .report   (report),
        .count    (count)
    );

    dpt_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .report   (report),
        .out_ready(m_tready),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (s_tready),
        .out_valid(m_tvalid)
    );

    dpt_conv #(
        .COUNT_BITS(COUNT_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) u_conv (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .count     (count),
        .stat      (stat),
        .ascii_char(m_tdata)
    );

    assign m_tlast = ctrl.out_nl;

endmodule

// ===== sv/dpt_front.sv =====
// debouncer state machine and saturating press duration counter
// depends on dpt_pkg
module dpt_front #(
    parameter int COUNT_BITS = dpt_pkg::DEF_COUNT_BITS,
    parameter int MAX_DIGITS = dpt_pkg::DEF_MAX_DIGITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic                  pin_level,
    input  logic [15:0]           step_inc,
    output logic                  report,
    output logic [COUNT_BITS-1:0] count
);

    localparam int SUM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam logic [COUNT_BITS-1:0] LIMIT =
        COUNT_BITS'(dpt_pkg::count_limit(COUNT_BITS, MAX_DIGITS));

    dpt_pkg::db_state_t    state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SUM_W-1:0]      sum;
    logic                  pressed;

    assign pressed = ~pin_level;
    assign sum     = SUM_W'(count_reg) + SUM_W'(step_inc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dpt_pkg::DB_UP;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        report     = 1'b0;
        if (in_fire) begin
            case (state_reg)
                dpt_pkg::DB_UP: begin
                    if (pressed) state_next = dpt_pkg::DB_FALLING;
                end
                dpt_pkg::DB_FALLING: begin
                    state_next = pressed ? dpt_pkg::DB_DOWN : dpt_pkg::DB_UP;
                end
                dpt_pkg::DB_DOWN: begin
                    count_next = (sum > SUM_W'(LIMIT)) ? LIMIT : sum[COUNT_BITS-1:0];
                    if (!pressed) state_next = dpt_pkg::DB_RISING;
                end
                dpt_pkg::DB_RISING: begin
                    if (pressed) begin
                        state_next = dpt_pkg::DB_DOWN;
                    end else begin
                        state_next = dpt_pkg::DB_UP;
                        report     = 1'b1;
                        count_next = '0;
                    end
                end
                default: state_next = dpt_pkg::DB_UP;
            endcase
        end
    end

    // value taken by the converter on the report edge, before clearing
    assign count = count_reg;

endmodule

// ===== sv/dpt_seq.sv =====
// microcode sequencer: step counter, control table lookup, conditional jumps
// depends on dpt_pkg
module dpt_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            report,
    input  logic            out_ready,
    input  dpt_pkg::stat_t  stat,
    output dpt_pkg::ctrl_t  ctrl,
    output logic            in_ready,
    output logic            out_valid
);

    dpt_pkg::pc_t   pc_reg, pc_next;
    dpt_pkg::ucode_t cw;
    logic           jump;
    logic           step_go;

    assign cw = dpt_pkg::rom_word(pc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= dpt_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    always_comb begin
        case (cw.cond)
            dpt_pkg::COND_ALWAYS:     jump = 1'b1;
            dpt_pkg::COND_REPORT:     jump = report;
            dpt_pkg::COND_BIT_LAST:   jump = stat.bit_last;
            dpt_pkg::COND_LEAD_END:   jump = stat.lead_end;
            dpt_pkg::COND_DIGIT_DONE: jump = out_ready & stat.idx_zero;
            dpt_pkg::COND_OUT_ACK:    jump = out_ready;
            default:                  jump = 1'b1;
        endcase
    end

    // an output step only moves on when its item is taken
    assign step_go = ~cw.out_valid | out_ready;
    assign pc_next = jump ? cw.target : pc_reg;

    assign ctrl.load    = cw.load & jump;
    assign ctrl.shift   = cw.shift;
    assign ctrl.idx_dec = cw.idx_dec & step_go & ~jump;
    assign ctrl.out_nl  = cw.out_nl;
    assign in_ready     = cw.in_ready;
    assign out_valid    = cw.out_valid;

endmodule

// ===== sv/dpt_conv.sv =====
// bit-serial binary to bcd converter, digit buffer and character select
// depends on dpt_pkg
module dpt_conv #(
    parameter int COUNT_BITS = dpt_pkg::DEF_COUNT_BITS,
    parameter int MAX_DIGITS = dpt_pkg::DEF_MAX_DIGITS
) (
    input  logic                  aclk,
    input  dpt_pkg::ctrl_t        ctrl,
    input  logic [COUNT_BITS-1:0] count,
    output dpt_pkg::stat_t        stat,
    output logic [7:0]            ascii_char
);

    localparam int CNT_W = $clog2(COUNT_BITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    logic [COUNT_BITS-1:0] bin_reg;
    logic [3:0]            digit_reg [MAX_DIGITS];
    logic [3:0]            adj       [MAX_DIGITS];
    logic [CNT_W-1:0]      bitcnt_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [3:0]            cur_digit;

    // add-3 correction on every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            adj[i] = (digit_reg[i] >= 4'd5) ? digit_reg[i] + 4'd3 : digit_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            bin_reg    <= count;
            bitcnt_reg <= CNT_W'(COUNT_BITS);
            idx_reg    <= IDX_W'(MAX_DIGITS - 1);
            for (int i = 0; i < MAX_DIGITS; i++) begin
                digit_reg[i] <= 4'd0;
            end
        end else begin
            if (ctrl.shift) begin
                bin_reg      <= {bin_reg[COUNT_BITS-2:0], 1'b0};
                bitcnt_reg   <= bitcnt_reg - CNT_W'(1);
                digit_reg[0] <= {adj[0][2:0], bin_reg[COUNT_BITS-1]};
                for (int i = 1; i < MAX_DIGITS; i++) begin
                    digit_reg[i] <= {adj[i][2:0], adj[i-1][3]};
                end
            end
            if (ctrl.idx_dec) begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    assign cur_digit     = digit_reg[idx_reg];
    assign stat.bit_last = (bitcnt_reg == CNT_W'(1));
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.lead_end = (cur_digit != 4'd0) | stat.idx_zero;

    assign ascii_char = ctrl.out_nl ? dpt_pkg::CHAR_NEWLINE
                                    : dpt_pkg::CHAR_ZERO + {4'd0, cur_digit};

endmodule

// ===== sv/dpt_checker.sv =====
// port-level checks for the debounced press timer, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module dpt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // samples are only taken between reports
    `ASSERT_IMPLIES(a_no_overlap, aclk, aresetn, s_tready, !m_tvalid, "input ready during report")

    `ASSERT_IMPLIES(a_newline, aclk, aresetn, m_tvalid && m_tlast, m_tdata == 8'd10, "last item is not a newline")

    `ASSERT_IMPLIES(a_digit, aclk, aresetn, m_tvalid && !m_tlast, m_tdata >= 8'd48 && m_tdata <= 8'd57, "non-digit character")

    // after the newline goes out the block is back waiting for samples
    `ASSERT_NEXT(a_report_end, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready, "no return to idle after report")

endmodule

bind debounced_press_timer_ascii dpt_checker u_dpt_checker (.*);
